// ===== hdl/mm3_pkg.sv =====
// Shared types and constants for the 3x3 matrix multiplier.
// No dependencies; imported by mm3_ctrl, mm3_dpath, matrix_multiply_3x3_core and the testbench.
`default_nettype none

package mm3_pkg;

    localparam int DIM_DEF        = 3;
    localparam int ELEM_WIDTH_DEF = 16;
    localparam int IDX_W          = 2;   // row/col field width on the ports
    localparam int REQ_W          = 2;
    localparam int PROD_W         = 33;  // product field width, sum kept modulo 2^PROD_W

    typedef enum logic [REQ_W-1:0] {
        REQ_LOAD_A  = 2'd0,
        REQ_LOAD_B  = 2'd1,
        REQ_COMPUTE = 2'd2
    } t_req;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_ISSUE,
        ST_WAIT1,
        ST_WAIT2,
        ST_EMIT
    } t_state;

    typedef struct packed {
        logic wr_a;      // write element of A
        logic wr_b;      // write element of B
        logic issue;     // read A[i][k], B[k][j] into the MAC pipe
        logic first;     // issued term is k == 0, restarts the accumulator
        logic load_out;  // move accumulator into the output register
        logic last;      // element being loaded is the final one
    } t_cmd;

    typedef struct packed {
        logic out_free;  // output register empty or being drained this cycle
    } t_sts;

endpackage

`default_nettype wire

// ===== hdl/mm3_ctrl.sv =====
// Controller FSM for the matrix multiplier: input handshake and i/j/k sequencing.
// Depends on mm3_pkg; drives mm3_dpath through t_cmd and reads t_sts.
`default_nettype none

module mm3_ctrl
    import mm3_pkg::*;
#(
    parameter int DIM = DIM_DEF
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_rst_n,
    input  wire logic                     i_valid,
    input  wire logic [REQ_W-1:0]         i_req_type,
    input  wire logic [IDX_W-1:0]         i_row,
    input  wire logic [IDX_W-1:0]         i_col,
    output logic                          o_ready,
    input  wire t_sts                     i_sts,
    output t_cmd                          o_cmd,
    output logic [$clog2(DIM)-1:0]        o_idx_i,
    output logic [$clog2(DIM)-1:0]        o_idx_j,
    output logic [$clog2(DIM)-1:0]        o_idx_k
);

    localparam int IW = $clog2(DIM);
    localparam logic [IW-1:0] LAST_IDX = IW'(DIM - 1);

    t_state          r_state, n_state;
    logic [IW-1:0]   r_i, n_i;
    logic [IW-1:0]   r_j, n_j;
    logic [IW-1:0]   r_k, n_k;
    logic            accept;
    logic            in_range;
    logic            elem_last;

    assign accept    = i_valid && o_ready;
    assign in_range  = (32'(i_row) < DIM) && (32'(i_col) < DIM);
    assign elem_last = (r_i == LAST_IDX) && (r_j == LAST_IDX);

    // next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_IDLE: begin
                if (accept && (i_req_type == REQ_COMPUTE)) n_state = ST_ISSUE;
            end
            ST_ISSUE: begin
                if (r_k == LAST_IDX) n_state = ST_WAIT1;
            end
            ST_WAIT1: n_state = ST_WAIT2;
            ST_WAIT2: n_state = ST_EMIT;
            ST_EMIT: begin
                if (i_sts.out_free) n_state = elem_last ? ST_IDLE : ST_ISSUE;
            end
            default: n_state = ST_IDLE;
        endcase
    end

    // outputs; ready is high throughout idle, so valid alone marks a write
    always_comb begin
        o_ready = 1'b0;
        o_cmd   = '0;
        case (r_state)
            ST_IDLE: begin
                o_ready    = 1'b1;
                o_cmd.wr_a = i_valid && in_range && (i_req_type == REQ_LOAD_A);
                o_cmd.wr_b = i_valid && in_range && (i_req_type == REQ_LOAD_B);
            end
            ST_ISSUE: begin
                o_cmd.issue = 1'b1;
                o_cmd.first = (r_k == '0);
            end
            ST_EMIT: begin
                o_cmd.load_out = i_sts.out_free;
                o_cmd.last     = elem_last;
            end
            default: o_cmd = '0;
        endcase
    end

    // loop counters
    always_comb begin
        n_i = r_i;
        n_j = r_j;
        n_k = r_k;
        case (r_state)
            ST_IDLE: begin
                n_i = '0;
                n_j = '0;
                n_k = '0;
            end
            ST_ISSUE: begin
                n_k = (r_k == LAST_IDX) ? '0 : r_k + 1'b1;
            end
            ST_EMIT: begin
                if (i_sts.out_free && !elem_last) begin
                    if (r_j == LAST_IDX) begin
                        n_j = '0;
                        n_i = r_i + 1'b1;
                    end else begin
                        n_j = r_j + 1'b1;
                    end
                end
            end
            default: n_k = r_k;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_i     <= '0;
            r_j     <= '0;
            r_k     <= '0;
        end else begin
            r_state <= n_state;
            r_i     <= n_i;
            r_j     <= n_j;
            r_k     <= n_k;
        end
    end

    assign o_idx_i = r_i;
    assign o_idx_j = r_j;
    assign o_idx_k = r_k;

    a_no_write_while_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_cmd.wr_a || o_cmd.wr_b) |-> !o_cmd.issue && !o_cmd.load_out)
        else $error("matrix write overlaps a compute");

    a_last_returns_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_cmd.load_out && o_cmd.last) |=> (r_state == ST_IDLE))
        else $error("controller did not return to idle after final element");

    a_issue_restarts_at_k0: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ($rose(o_cmd.issue)) |-> o_cmd.first)
        else $error("dot product started at nonzero k");

endmodule

`default_nettype wire

// ===== hdl/mm3_dpath.sv =====
// Datapath: A/B element memories, registered multiply, accumulator, output register.
// Depends on mm3_pkg; commanded by mm3_ctrl.
`default_nettype none

module mm3_dpath
    import mm3_pkg::*;
#(
    parameter int DIM        = DIM_DEF,
    parameter int ELEM_WIDTH = ELEM_WIDTH_DEF
) (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire t_cmd                          i_cmd,
    input  wire logic [IDX_W-1:0]              i_row,
    input  wire logic [IDX_W-1:0]              i_col,
    input  wire logic signed [ELEM_WIDTH-1:0]  i_elem_value,
    input  wire logic [$clog2(DIM)-1:0]        i_idx_i,
    input  wire logic [$clog2(DIM)-1:0]        i_idx_j,
    input  wire logic [$clog2(DIM)-1:0]        i_idx_k,
    input  wire logic                          i_out_ready,
    output t_sts                               o_sts,
    output logic                               o_valid,
    output logic [IDX_W-1:0]                   o_out_row,
    output logic [IDX_W-1:0]                   o_out_col,
    output logic signed [PROD_W-1:0]           o_product_value,
    output logic                               o_last
);

    localparam int DEPTH = DIM * DIM;
    localparam int AW    = $clog2(DEPTH);
    localparam int PW    = 2 * ELEM_WIDTH;
    localparam int XW    = (PW > PROD_W) ? PW : PROD_W;

    logic signed [ELEM_WIDTH-1:0] r_mem_a [DEPTH];
    logic signed [ELEM_WIDTH-1:0] r_mem_b [DEPTH];

    logic [AW-1:0]                wr_addr;
    logic [AW-1:0]                a_addr;
    logic [AW-1:0]                b_addr;
    logic signed [ELEM_WIDTH-1:0] r_a_rd;
    logic signed [ELEM_WIDTH-1:0] r_b_rd;
    logic                         r_v1, r_first1;
    logic signed [PW-1:0]         r_prod;
    logic                         r_v2, r_first2;
    logic signed [XW-1:0]         prod_ext;
    logic signed [PROD_W-1:0]     r_acc;
    logic                         r_out_valid;
    logic [IDX_W-1:0]             r_out_row;
    logic [IDX_W-1:0]             r_out_col;
    logic signed [PROD_W-1:0]     r_out_value;
    logic                         r_out_last;

    assign wr_addr = AW'(int'(i_row) * DIM + int'(i_col));
    assign a_addr  = AW'(int'(i_idx_i) * DIM + int'(i_idx_k));
    assign b_addr  = AW'(int'(i_idx_k) * DIM + int'(i_idx_j));

    always_ff @(posedge i_clk) begin
        if (i_cmd.wr_a) r_mem_a[wr_addr] <= i_elem_value;
        if (i_cmd.wr_b) r_mem_b[wr_addr] <= i_elem_value;
        r_a_rd <= r_mem_a[a_addr];
        r_b_rd <= r_mem_b[b_addr];
    end

    // MAC pipe: read -> multiply -> accumulate
    always_ff @(posedge i_clk) begin
        r_first1 <= i_cmd.first;
        r_prod   <= r_a_rd * r_b_rd;
        r_first2 <= r_first1;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
        end else begin
            r_v1 <= i_cmd.issue;
            r_v2 <= r_v1;
        end
    end

    assign prod_ext = XW'(r_prod);

    always_ff @(posedge i_clk) begin
        if (r_v2) begin
            r_acc <= r_first2 ? prod_ext[PROD_W-1:0] : r_acc + prod_ext[PROD_W-1:0];
        end
    end

    // output register
    assign o_sts.out_free = !r_out_valid || i_out_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.load_out) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load_out) begin
            r_out_row   <= IDX_W'(i_idx_i);
            r_out_col   <= IDX_W'(i_idx_j);
            r_out_value <= r_acc;
            r_out_last  <= i_cmd.last;
        end
    end

    assign o_valid         = r_out_valid;
    assign o_out_row       = r_out_row;
    assign o_out_col       = r_out_col;
    assign o_product_value = r_out_value;
    assign o_last          = r_out_last;

    a_load_only_when_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.load_out |-> o_sts.out_free)
        else $error("output register overwritten while holding a request");

    a_pipe_drained_at_emit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.load_out |-> !r_v1 && !r_v2 && !i_cmd.issue)
        else $error("accumulator taken before its last term arrived");

    a_out_held_on_stall: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && !i_out_ready) |=>
            (o_valid && $stable(o_product_value) && $stable(o_last)))
        else $error("stalled result changed before it was taken");

endmodule

`default_nettype wire

// ===== hdl/matrix_multiply_3x3_core.sv =====
// Top level of the DIM x DIM signed matrix multiplier.
// Depends on mm3_pkg, mm3_ctrl and mm3_dpath.
//
// Input channel (i_valid / o_ready): one request per handshake.
//   req_type LOAD_A / LOAD_B writes elem_value to A[row][col] / B[row][col];
//   a row or col of DIM or more is dropped. Loads are accepted back to back.
//   COMPUTE emits all DIM*DIM elements of A*B in row-major order; o_last marks
//   the final one. req_type 3 is taken and ignored.
// Output channel (o_valid / i_ready): out_row, out_col, product_value, last.
// Each product element runs one read of A[i][k] and B[k][j] per k through a shared
// registered multiplier and accumulator, then drains the pipe (WAIT1, WAIT2) and
// loads the output register in EMIT; a receiver holding i_ready low stalls the sequence.
// No new request is taken while a compute request is in progress.
// The first result leaves once the first element has passed ISSUE, WAIT1, WAIT2 and EMIT.
// A stalled receiver holds the output register and the sequencer waits; the
// next request is accepted once the final element is in the output register.
// Reset clears the controller and output valid; matrix contents are undefined
// until written.
`default_nettype none

module matrix_multiply_3x3_core
    import mm3_pkg::*;
#(
    parameter int DIM        = DIM_DEF,
    parameter int ELEM_WIDTH = ELEM_WIDTH_DEF
) (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire logic                          i_valid,
    output logic                               o_ready,
    input  wire logic [REQ_W-1:0]              i_req_type,
    input  wire logic [IDX_W-1:0]              i_row,
    input  wire logic [IDX_W-1:0]              i_col,
    input  wire logic signed [ELEM_WIDTH-1:0]  i_elem_value,
    output logic                               o_valid,
    input  wire logic                          i_ready,
    output logic [IDX_W-1:0]                   o_out_row,
    output logic [IDX_W-1:0]                   o_out_col,
    output logic signed [PROD_W-1:0]           o_product_value,
    output logic                               o_last
);

    localparam int IW = $clog2(DIM);

    t_cmd          cmd;
    t_sts          sts;
    logic [IW-1:0] idx_i;
    logic [IW-1:0] idx_j;
    logic [IW-1:0] idx_k;

    mm3_ctrl #(
        .DIM(DIM)
    ) u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_valid    (i_valid),
        .i_req_type (i_req_type),
        .i_row      (i_row),
        .i_col      (i_col),
        .o_ready    (o_ready),
        .i_sts      (sts),
        .o_cmd      (cmd),
        .o_idx_i    (idx_i),
        .o_idx_j    (idx_j),
        .o_idx_k    (idx_k)
    );

    mm3_dpath #(
        .DIM        (DIM),
        .ELEM_WIDTH (ELEM_WIDTH)
    ) u_dpath (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cmd           (cmd),
        .i_row           (i_row),
        .i_col           (i_col),
        .i_elem_value    (i_elem_value),
        .i_idx_i         (idx_i),
        .i_idx_j         (idx_j),
        .i_idx_k         (idx_k),
        .i_out_ready     (i_ready),
        .o_sts           (sts),
        .o_valid         (o_valid),
        .o_out_row       (o_out_row),
        .o_out_col       (o_out_col),
        .o_product_value (o_product_value),
        .o_last          (o_last)
    );

endmodule

`default_nettype wire

// ===== tb/testbench.sv =====
// Self-checking testbench for matrix_multiply_3x3_core: random and directed loads of A/B,
// compute requests checked against an in-bench matrix product predictor.
// Depends on mm3_pkg and matrix_multiply_3x3_core.
`timescale 1ns / 100ps

module testbench
    import mm3_pkg::*;
();

    localparam int DIM            = DIM_DEF;
    localparam int EW             = ELEM_WIDTH_DEF;
    localparam int RANDOM_TARGET  = 305;
    localparam int WATCHDOG_LIMIT = 2000;
    localparam int DRAIN_CYCLES   = 4 * (DIM + 3);
    localparam int IDLE_PCT       = 28;
    localparam int MAX_PRINTED    = 100;
    localparam logic [REQ_W-1:0] REQ_UNUSED = 2'd3;

    typedef struct {
        logic [REQ_W-1:0]     kind;
        logic [IDX_W-1:0]     row;
        logic [IDX_W-1:0]     col;
        logic signed [EW-1:0] value;
    } t_request;

    typedef struct {
        logic [IDX_W-1:0]         row;
        logic [IDX_W-1:0]         col;
        logic signed [PROD_W-1:0] value;
        logic                     last;
    } t_product;

    logic                      i_clk        = 1'b0;
    logic                      i_rst_n      = 1'b0;
    logic                      i_valid      = 1'b0;
    logic                      o_ready;
    logic [REQ_W-1:0]          i_req_type   = '0;
    logic [IDX_W-1:0]          i_row        = '0;
    logic [IDX_W-1:0]          i_col        = '0;
    logic signed [EW-1:0]      i_elem_value = '0;
    logic                      o_valid;
    logic                      i_ready      = 1'b0;
    logic [IDX_W-1:0]          o_out_row;
    logic [IDX_W-1:0]          o_out_col;
    logic signed [PROD_W-1:0]  o_product_value;
    logic                      o_last;

    t_request             pending_reqs[$];
    t_request             held_req;
    t_product             expected_products[$];
    t_product             head_product;
    logic signed [EW-1:0] a_elems[DIM*DIM];
    logic signed [EW-1:0] b_elems[DIM*DIM];
    int                   total_reqs;
    int                   accepted_reqs;
    int                   error_count;
    int                   quiet_cycles;
    logic                 steady_run;

    matrix_multiply_3x3_core u_dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_valid         (i_valid),
        .o_ready         (o_ready),
        .i_req_type      (i_req_type),
        .i_row           (i_row),
        .i_col           (i_col),
        .i_elem_value    (i_elem_value),
        .o_valid         (o_valid),
        .i_ready         (i_ready),
        .o_out_row       (o_out_row),
        .o_out_col       (o_out_col),
        .o_product_value (o_product_value),
        .o_last          (o_last)
    );

    initial begin
        forever #5 i_clk = ~i_clk;
    end

    // no idling on either side through a long middle stretch
    assign steady_run = (accepted_reqs >= 150) && (accepted_reqs < 230);

    task automatic report_mismatch(input string msg);
        if (error_count < MAX_PRINTED)
            $display("[%0t] MISMATCH: %s", $time, msg);
        error_count++;
    endtask

    task automatic queue_req(input logic [REQ_W-1:0] kind, input logic [IDX_W-1:0] row,
                             input logic [IDX_W-1:0] col, input logic signed [EW-1:0] value);
        t_request r;
        r.kind  = kind;
        r.row   = row;
        r.col   = col;
        r.value = value;
        pending_reqs.push_back(r);
        total_reqs++;
    endtask

    function automatic logic signed [EW-1:0] pick_elem();
        case ($urandom_range(9))
            0:       return {1'b1, {(EW-1){1'b0}}};
            1:       return {1'b0, {(EW-1){1'b1}}};
            2:       return '0;
            3:       return '1;
            default: return EW'($urandom);
        endcase
    endfunction

    // Matrix state update for loads; full product expansion for a compute request.
    function automatic void apply_request(input t_request r);
        longint   acc;
        t_product p;
        if (r.kind == REQ_LOAD_A || r.kind == REQ_LOAD_B) begin
            if (r.row < DIM && r.col < DIM) begin
                if (r.kind == REQ_LOAD_A)
                    a_elems[r.row*DIM + r.col] = r.value;
                else
                    b_elems[r.row*DIM + r.col] = r.value;
            end
        end else if (r.kind == REQ_COMPUTE) begin
            for (int i = 0; i < DIM; i++) begin
                for (int j = 0; j < DIM; j++) begin
                    acc = 0;
                    for (int k = 0; k < DIM; k++)
                        acc += longint'(a_elems[i*DIM + k]) * longint'(b_elems[k*DIM + j]);
                    p.row   = IDX_W'(i);
                    p.col   = IDX_W'(j);
                    p.value = acc[PROD_W-1:0];
                    p.last  = (i == DIM-1) && (j == DIM-1);
                    expected_products.push_back(p);
                end
            end
        end
    endfunction

    // request driver
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_valid <= 1'b0;
        end else begin
            if (i_valid && o_ready) begin
                apply_request(held_req);
                accepted_reqs++;
            end
            if (!i_valid || o_ready) begin
                if (pending_reqs.size() != 0 &&
                    (steady_run || $urandom_range(99) >= IDLE_PCT)) begin
                    held_req      = pending_reqs.pop_front();
                    i_req_type   <= held_req.kind;
                    i_row        <= held_req.row;
                    i_col        <= held_req.col;
                    i_elem_value <= held_req.value;
                    i_valid      <= 1'b1;
                end else begin
                    i_valid <= 1'b0;
                end
            end
        end
    end

    // result monitor
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_ready <= 1'b0;
        end else begin
            if (o_valid && i_ready) begin
                if (expected_products.size() == 0) begin
                    report_mismatch($sformatf("unexpected result row %0d col %0d value %0d",
                                              o_out_row, o_out_col, o_product_value));
                end else begin
                    head_product = expected_products.pop_front();
                    if (o_out_row !== head_product.row)
                        report_mismatch($sformatf("out_row got %0d want %0d",
                                                  o_out_row, head_product.row));
                    if (o_out_col !== head_product.col)
                        report_mismatch($sformatf("out_col got %0d want %0d",
                                                  o_out_col, head_product.col));
                    if (o_product_value !== head_product.value)
                        report_mismatch($sformatf("product [%0d][%0d] got %0d want %0d",
                                                  head_product.row, head_product.col,
                                                  o_product_value, head_product.value));
                    if (o_last !== head_product.last)
                        report_mismatch($sformatf("last [%0d][%0d] got %0b want %0b",
                                                  head_product.row, head_product.col,
                                                  o_last, head_product.last));
                end
            end
            i_ready <= steady_run || ($urandom_range(99) >= IDLE_PCT);
        end
    end

    // watchdog: cycles with no handshake on either channel
    always @(posedge i_clk) begin
        if (!i_rst_n || (i_valid && o_ready) || (o_valid && i_ready))
            quiet_cycles = 0;
        else
            quiet_cycles++;
    end

    initial begin
        int                   counted;
        int                   n;
        logic [REQ_W-1:0]     kind;
        logic [IDX_W-1:0]     row;
        logic [IDX_W-1:0]     col;
        logic signed [EW-1:0] max_neg;
        logic signed [EW-1:0] max_pos;

        total_reqs    = 0;
        accepted_reqs = 0;
        error_count   = 0;
        quiet_cycles  = 0;
        counted       = 0;
        max_neg       = {1'b1, {(EW-1){1'b0}}};
        max_pos       = {1'b0, {(EW-1){1'b1}}};
        foreach (a_elems[i]) begin
            a_elems[i] = '0;
            b_elems[i] = '0;
        end

        // Fill both matrices first so no compute ever reads an unwritten element.
        // Row 0 of A against column 0/1 of B hits the most positive and most negative sums.
        for (int c = 0; c < DIM; c++) begin
            queue_req(REQ_LOAD_A, IDX_W'(0), IDX_W'(c), max_neg);
            queue_req(REQ_LOAD_A, IDX_W'(1), IDX_W'(c), max_pos);
        end
        queue_req(REQ_LOAD_A, IDX_W'(2), IDX_W'(0), EW'(0));
        queue_req(REQ_LOAD_A, IDX_W'(2), IDX_W'(1), EW'(1));
        queue_req(REQ_LOAD_A, IDX_W'(2), IDX_W'(2), EW'(-1));
        for (int k = 0; k < DIM; k++) begin
            queue_req(REQ_LOAD_B, IDX_W'(k), IDX_W'(0), max_neg);
            queue_req(REQ_LOAD_B, IDX_W'(k), IDX_W'(1), max_pos);
            queue_req(REQ_LOAD_B, IDX_W'(k), IDX_W'(2), EW'(k - 1));
        end
        queue_req(REQ_COMPUTE, IDX_W'(0), IDX_W'(0), EW'(0));
        // out-of-range indexes and the unused code must leave the matrices alone
        queue_req(REQ_LOAD_A, IDX_W'(3), IDX_W'(0), EW'(12345));
        queue_req(REQ_LOAD_B, IDX_W'(0), IDX_W'(3), EW'(-7));
        queue_req(REQ_LOAD_A, IDX_W'(3), IDX_W'(3), max_pos);
        queue_req(REQ_UNUSED, IDX_W'(1), IDX_W'(1), EW'(999));
        queue_req(REQ_COMPUTE, IDX_W'(3), IDX_W'(3), EW'(-1));

        // Mostly partial reloads followed by a compute, with some noise mixed in.
        while (counted < RANDOM_TARGET) begin
            if ($urandom_range(99) < 85) begin
                n = $urandom_range(1, 9);
                repeat (n) begin
                    kind = $urandom_range(1) ? REQ_LOAD_B : REQ_LOAD_A;
                    queue_req(kind, IDX_W'($urandom_range(DIM-1)),
                              IDX_W'($urandom_range(DIM-1)), pick_elem());
                end
                queue_req(REQ_COMPUTE, IDX_W'($urandom_range(3)), IDX_W'($urandom_range(3)),
                          pick_elem());
                counted += n + 1;
            end else begin
                repeat ($urandom_range(1, 4)) begin
                    kind = REQ_W'($urandom_range(3));
                    row  = IDX_W'($urandom_range(3));
                    col  = IDX_W'($urandom_range(3));
                    queue_req(kind, row, col, pick_elem());
                    if (kind == REQ_COMPUTE ||
                        (kind != REQ_UNUSED && row < DIM && col < DIM))
                        counted++;
                end
            end
        end

        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;

        while ((accepted_reqs != total_reqs || expected_products.size() != 0) &&
               quiet_cycles < WATCHDOG_LIMIT)
            @(posedge i_clk);

        if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("Regression FAIL");
        end else begin
            repeat (DRAIN_CYCLES) @(posedge i_clk);
            if (error_count == 0 && expected_products.size() == 0)
                $display("Regression PASS");
            else
                $display("Regression FAIL");
        end
        $finish;
    end

endmodule
